>>> design/iir_direct_form2_transposed_unit_defines.svh
// Assertion macros for the IIR transposed direct form II unit.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef IIR_DIRECT_FORM2_TRANSPOSED_UNIT_DEFINES_SVH
`define IIR_DIRECT_FORM2_TRANSPOSED_UNIT_DEFINES_SVH

// same-cycle implication
`define IIRDF2T_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IIRDF2T_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/iirdf2t_pkg.sv
// Package for the IIR transposed direct form II unit: widths, command codes,
// sequencer states and the multiplier request type. No dependencies.
`timescale 1ns / 1ps

package iirdf2t_pkg;

  localparam int MAX_ORDER = 8;

  localparam int XW     = 24;                 // sample, Q1.23
  localparam int KW     = 32;                 // coefficient, Q4.28
  localparam int STW    = 48;                 // state, Q8.40
  localparam int IW     = 4;                  // entry index
  localparam int CMDW   = 3;
  localparam int ORDW   = 4;                  // order register
  localparam int PW     = KW + XW;            // full product, Q.51
  localparam int RND_SH = 11;
  localparam int RW     = PW - RND_SH;        // rounded product, Q.40
  localparam int Y_SH   = 17;

  localparam int CW = $clog2(MAX_ORDER + 1);                    // coef index
  localparam int SW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;  // state index
  localparam int OW = CW;                                       // effective order
  localparam int AW = (CW > IW) ? CW : IW;                      // shared address

  localparam logic [ORDW-1:0] ORDER_RESET = ORDW'(8);

  localparam logic [CMDW-1:0] CMD_SAMPLE   = 3'd0;
  localparam logic [CMDW-1:0] CMD_WR_NUM   = 3'd1;
  localparam logic [CMDW-1:0] CMD_WR_DEN   = 3'd2;
  localparam logic [CMDW-1:0] CMD_WR_STATE = 3'd3;
  localparam logic [CMDW-1:0] CMD_RD_STATE = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B0,
    ST_Y,
    ST_AY,
    ST_UPD,
    ST_RES
  } iirdf2t_state_e;

  typedef struct packed {
    logic                 load;
    logic signed [KW-1:0] coef;
    logic signed [XW-1:0] opnd;
  } iirdf2t_mul_req_t;

endpackage

>>> design/iirdf2t_mul.sv
// Shared coefficient multiplier: registered 32x24 product, rounded half up
// to Q.40. Depends on iirdf2t_pkg.
`timescale 1ns / 1ps

module iirdf2t_mul (
  input  logic                                   clk_i,
  input  iirdf2t_pkg::iirdf2t_mul_req_t          req_i,
  output logic signed [iirdf2t_pkg::RW-1:0]      rnd_o
);
  import iirdf2t_pkg::*;

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] prod_sum;

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      prod_q <= PW'(req_i.coef) * PW'(req_i.opnd);
    end
  end

  assign prod_sum = prod_q + PW'(1 << (RND_SH - 1));
  assign rnd_o    = prod_sum[PW-1:RND_SH];

endmodule

>>> design/iir_direct_form2_transposed_unit.sv
// IIR filter, transposed direct form II, one shared multiplier under a sequencer.
// The one multiplier does 2*order+1 products per sample. No new command is taken
// until a sample's or state read's result is out; in idle, one write per cycle.
// A held result keeps the sequencer in its last step and in_ready_o low.
// Reset clears all coefficients and delay states and sets order_in_use to 8.
`timescale 1ns / 1ps
`include "iir_direct_form2_transposed_unit_defines.svh"

module iir_direct_form2_transposed_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [iirdf2t_pkg::ORDW-1:0]          cfg_order_in_use_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [iirdf2t_pkg::CMDW-1:0]          cmd_i,
  input  logic signed [iirdf2t_pkg::XW-1:0]     sample_in_i,
  input  logic [iirdf2t_pkg::IW-1:0]            entry_index_i,
  input  logic signed [iirdf2t_pkg::KW-1:0]     coef_value_i,
  input  logic signed [iirdf2t_pkg::STW-1:0]    state_value_i,
  input  logic                                  end_of_block_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  result_kind_o,
  output logic signed [iirdf2t_pkg::XW-1:0]     sample_out_o,
  output logic signed [iirdf2t_pkg::STW-1:0]    state_word_o,
  output logic                                  saturated_o,
  output logic                                  block_done_o
);
  import iirdf2t_pkg::*;

  localparam int YAW = STW + 1;
  localparam int YRW = YAW - Y_SH;
  localparam int UAW = STW + 2;
  localparam logic signed [YRW-1:0] Y_HI = {{(YRW-XW+1){1'b0}}, {(XW-1){1'b1}}};
  localparam logic signed [YRW-1:0] Y_LO = {{(YRW-XW+1){1'b1}}, {(XW-1){1'b0}}};
  localparam logic signed [UAW-1:0] S_HI = {{(UAW-STW+1){1'b0}}, {(STW-1){1'b1}}};
  localparam logic signed [UAW-1:0] S_LO = {{(UAW-STW+1){1'b1}}, {(STW-1){1'b0}}};

  iirdf2t_state_e state_q, state_d;
  logic [SW-1:0]  k_q, k_d;
  logic [ORDW-1:0] order_q;

  logic signed [KW-1:0]  num_q [MAX_ORDER+1];
  logic signed [KW-1:0]  den_q [MAX_ORDER+1];
  logic signed [STW-1:0] st_q  [MAX_ORDER];

  logic signed [XW-1:0]  x_q;
  logic                  eob_q;
  logic signed [XW-1:0]  y_q;
  logic                  sat_q;
  logic signed [RW-1:0]  bx_q;
  logic signed [STW-1:0] rdw_q;
  logic                  kind_q;

  logic                  out_valid_q;
  logic                  result_kind_q;
  logic signed [XW-1:0]  sample_out_q;
  logic signed [STW-1:0] state_word_q;
  logic                  saturated_q;
  logic                  block_done_q;

  logic                  in_xfer;
  logic                  out_free;
  logic [OW-1:0]         order_eff;
  logic [OW-1:0]         k_inc;
  logic                  last;
  logic [AW-1:0]         caddr;
  logic [AW-1:0]         saddr;
  logic signed [KW-1:0]  num_rd;
  logic signed [KW-1:0]  den_rd;
  logic                  st_ok;
  logic signed [STW-1:0] st_rd;
  logic signed [RW-1:0]  rnd;
  iirdf2t_mul_req_t      mreq;

  logic signed [YAW-1:0] y_acc;
  logic signed [YAW-1:0] y_sum;
  logic signed [YRW-1:0] y_rnd;
  logic signed [XW-1:0]  y_new;
  logic                  y_sat;
  logic signed [UAW-1:0] s_acc;
  logic signed [STW-1:0] s_new;

  iirdf2t_mul u_mul (
    .clk_i (clk_i),
    .req_i (mreq),
    .rnd_o (rnd)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign order_eff = (int'(order_q) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(order_q);
  assign k_inc     = OW'(k_q) + OW'(1);
  assign last      = (k_inc == order_eff);

  always_comb begin
    case (state_q)
      ST_Y:    caddr = AW'(1);
      ST_AY:   caddr = AW'(k_inc);
      ST_UPD:  caddr = AW'(k_inc) + AW'(1);
      default: caddr = '0;
    endcase
  end

  assign num_rd = (int'(caddr) <= MAX_ORDER) ? num_q[CW'(caddr)] : '0;
  assign den_rd = (int'(caddr) <= MAX_ORDER) ? den_q[CW'(caddr)] : '0;

  // one state read port: host read in idle, next state during the update
  assign saddr = (state_q == ST_IDLE) ? AW'(entry_index_i) : AW'(k_inc);
  assign st_ok = (int'(saddr) < MAX_ORDER) && ((state_q == ST_IDLE) || !last);
  assign st_rd = st_ok ? st_q[SW'(saddr)] : '0;

  // y = round(b0*x) + s0, rounded to Q1.23 and clipped
  always_comb begin
    y_acc = {{(YAW-RW){rnd[RW-1]}}, rnd};
    if (order_eff != '0) begin
      y_acc = y_acc + {st_q[0][STW-1], st_q[0]};
    end
    y_sum = y_acc + YAW'(1 << (Y_SH - 1));
    y_rnd = y_sum[YAW-1:Y_SH];
    y_sat = 1'b0;
    if (y_rnd > Y_HI) begin
      y_new = Y_HI[XW-1:0];
      y_sat = 1'b1;
    end else if (y_rnd < Y_LO) begin
      y_new = Y_LO[XW-1:0];
      y_sat = 1'b1;
    end else begin
      y_new = y_rnd[XW-1:0];
    end
  end

  // s[k] = round(b*x) - round(a*y) + s[k+1], clipped silently
  always_comb begin
    s_acc = {{(UAW-RW){bx_q[RW-1]}}, bx_q} - {{(UAW-RW){rnd[RW-1]}}, rnd}
          + {{(UAW-STW){st_rd[STW-1]}}, st_rd};
    if (s_acc > S_HI) begin
      s_new = S_HI[STW-1:0];
    end else if (s_acc < S_LO) begin
      s_new = S_LO[STW-1:0];
    end else begin
      s_new = s_acc[STW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    mreq.load = 1'b0;
    mreq.coef = num_rd;
    mreq.opnd = x_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_SAMPLE:   state_d = ST_B0;
            CMD_RD_STATE: state_d = ST_RES;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_B0: begin
        mreq.load = 1'b1;
        state_d   = ST_Y;
      end
      ST_Y: begin
        if (order_eff == '0) begin
          state_d = ST_RES;
        end else begin
          mreq.load = 1'b1;
          k_d       = '0;
          state_d   = ST_AY;
        end
      end
      ST_AY: begin
        mreq.load = 1'b1;
        mreq.coef = den_rd;
        mreq.opnd = y_q;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        if (last) begin
          state_d = ST_RES;
        end else begin
          mreq.load = 1'b1;
          k_d       = k_q + SW'(1);
          state_d   = ST_AY;
        end
      end
      ST_RES: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      order_q <= cfg_order_in_use_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        num_q[i] <= '0;
        den_q[i] <= '0;
      end
      for (int i = 0; i < MAX_ORDER; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      if (in_xfer) begin
        case (cmd_i)
          CMD_WR_NUM: begin
            if (int'(entry_index_i) <= MAX_ORDER) begin
              num_q[CW'(entry_index_i)] <= coef_value_i;
            end
          end
          CMD_WR_DEN: begin
            if (int'(entry_index_i) <= MAX_ORDER) begin
              den_q[CW'(entry_index_i)] <= coef_value_i;
            end
          end
          CMD_WR_STATE: begin
            if (int'(entry_index_i) < MAX_ORDER) begin
              st_q[SW'(entry_index_i)] <= state_value_i;
            end
          end
          default: ;
        endcase
      end
      if (state_q == ST_UPD) begin
        st_q[k_q] <= s_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q    <= sample_in_i;
      eob_q  <= end_of_block_i;
      rdw_q  <= st_rd;
      kind_q <= (cmd_i == CMD_RD_STATE);
    end
    if (state_q == ST_Y) begin
      y_q   <= y_new;
      sat_q <= y_sat;
    end
    if (state_q == ST_AY) begin
      bx_q <= rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_RES) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RES) && out_free) begin
      result_kind_q <= kind_q;
      if (kind_q) begin
        sample_out_q <= '0;
        saturated_q  <= 1'b0;
        block_done_q <= 1'b0;
        state_word_q <= rdw_q;
      end else begin
        sample_out_q <= y_q;
        saturated_q  <= sat_q;
        block_done_q <= eob_q;
        state_word_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = result_kind_q;
  assign sample_out_o  = sample_out_q;
  assign state_word_o  = state_word_q;
  assign saturated_o   = saturated_q;
  assign block_done_o  = block_done_q;

  `IIRDF2T_ASSERT_NEXT(a_smp_start, in_xfer && (cmd_i == CMD_SAMPLE), state_q == ST_B0, "sample transfer did not start the multiply sequence")
  `IIRDF2T_ASSERT_NOW(a_loop_bound, (state_q == ST_AY) || (state_q == ST_UPD), (order_eff != '0) && (k_inc <= order_eff), "state loop ran past the order in use")
  `IIRDF2T_ASSERT_NOW(a_rd_fields, out_valid_o && result_kind_o, (sample_out_o == '0) && !saturated_o && !block_done_o, "state read result carries sample fields")
  `IIRDF2T_ASSERT_NOW(a_smp_fields, out_valid_o && !result_kind_o, state_word_o == '0, "sample result carries a state word")

endmodule
